// ----- design/ens_pkg.sv -----
// shared types and constants of the encoder speed measurement block
package ens_pkg;

  // configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_CPW_A       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CPW_B       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INVERT      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_CLK    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_TICK = 3'd4;

  // register widths and reset values
  localparam int CPW_W  = 17;
  localparam int INV_W  = 2;
  localparam int BCLK_W = 32;
  localparam int SPT_W  = 31;
  localparam logic [CPW_W-1:0]  CPW_RST  = 17'd4096;
  localparam logic [INV_W-1:0]  INV_RST  = 2'd0;
  localparam logic [BCLK_W-1:0] BCLK_RST = 32'd72000000;
  localparam logic [SPT_W-1:0]  SPT_RST  = 31'd72000;

  // command codes
  localparam logic [1:0] CMD_WRAP_UP   = 2'd0;
  localparam logic [1:0] CMD_WRAP_DOWN = 2'd1;
  localparam logic [1:0] CMD_MEASURE   = 2'd2;
  localparam logic [1:0] CMD_RESTART   = 2'd3;

  // datapath widths
  localparam int WORD_W = 32;
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 33;
  localparam int TIME_W = 16;
  localparam int FIELD_CNT_W = 16;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } ens_sts_t;

endpackage

// ----- design/ens_mul.sv -----
// bit-serial shift-add multiplier, unsigned 32 x 32 to 64 bits
module ens_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ens_pkg::WORD_W-1:0]     a,
  input  logic [ens_pkg::WORD_W-1:0]     b,
  output logic [ens_pkg::NUM_W-1:0]      prod,
  output ens_pkg::ens_sts_t              sts
);

  localparam int STEP_W = $clog2(ens_pkg::WORD_W);

  logic [ens_pkg::NUM_W-1:0]  acc_r;
  logic [ens_pkg::WORD_W-1:0] a_r;
  logic [STEP_W-1:0]          step_r;
  logic                       busy_r;
  logic                       done_r;
  logic [ens_pkg::WORD_W:0]   sum;

  // add multiplicand into the upper half when the current multiplier bit is set
  assign sum = {1'b0, acc_r[ens_pkg::NUM_W-1:ens_pkg::WORD_W]}
             + {1'b0, (acc_r[0] ? a_r : '0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(ens_pkg::WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= {{ens_pkg::WORD_W{1'b0}}, b};
      a_r   <= a;
    end else if (busy_r) begin
      acc_r <= {sum, acc_r[ens_pkg::WORD_W-1:1]};
    end
  end

  assign prod     = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ----- design/ens_div.sv -----
// bit-serial restoring divider, unsigned 64 / 33 bits, one quotient bit per cycle
module ens_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ens_pkg::NUM_W-1:0]  num,
  input  logic [ens_pkg::DEN_W-1:0]  den,
  output logic [ens_pkg::NUM_W-1:0]  quo,
  output ens_pkg::ens_sts_t          sts
);

  localparam int STEP_W = $clog2(ens_pkg::NUM_W);

  logic [ens_pkg::NUM_W-1:0] shf_r;
  logic [ens_pkg::DEN_W-1:0] rem_r;
  logic [ens_pkg::DEN_W-1:0] den_r;
  logic [STEP_W-1:0]         step_r;
  logic                      busy_r;
  logic                      done_r;
  logic [ens_pkg::DEN_W:0]   trial;
  logic [ens_pkg::DEN_W:0]   diff;
  logic                      qbit;

  // partial remainder with next numerator bit, then trial subtract
  assign trial = {rem_r, shf_r[ens_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(ens_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      shf_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      shf_r <= {shf_r[ens_pkg::NUM_W-2:0], qbit};
      rem_r <= qbit ? diff[ens_pkg::DEN_W-1:0] : trial[ens_pkg::DEN_W-1:0];
    end
  end

  assign quo      = shf_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// ----- design/encoder_speed_measurement.sv -----
// top level of the quadrature encoder speed measurement block
//
//  port group | dir | contents
//  in_*       | in  | command words: tdata = encoder_count, base_time; tuser = command, channel
//  out_*      | out | results: tdata = speed, count_delta; tuser = divide_error
//  cfg_*      | in  | register writes, index 0..4, no read-back
//
// wrap and restart words go back to idle after the execute state; a first measurement
// goes on to the finish state; a full measurement runs the 32-step serial multiplier
// twice (wraps times counts per wrap, then delta times base clock), followed by
// a 64-step serial divider by elapsed ticks plus sample period; a zero divisor skips it
// reset (rst_n low, synchronous) clears wrap counts and history and arms the
// first-measurement path on every channel; configuration returns to defaults
// a finished result sits in the output register; the next word is taken
// while it waits, and only a second result stalls behind it
module encoder_speed_measurement #(
  parameter int CHANNELS   = 2,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input words
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // [15:0] encoder_count, [31:16] base_time
  input  logic [2:0]                        in_tuser,   // [1:0] command, [2] channel
  // result words
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [63:0]                       out_tdata,  // [31:0] speed, [63:32] count_delta
  output logic                              out_tuser,  // [0] divide_error
  // configuration writes
  input  logic                              cfg_we,
  input  logic [ens_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ens_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // counter bits actually used from the 16-bit field
  localparam int CNT_W = (COUNT_BITS < ens_pkg::FIELD_CNT_W) ? COUNT_BITS
                                                            : ens_pkg::FIELD_CNT_W;
  localparam int WW    = ens_pkg::WORD_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_PROD  = 3'd2;
  localparam logic [2:0] S_DELTA = 3'd3;
  localparam logic [2:0] S_MULGO = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // configuration registers
  logic [ens_pkg::CPW_W-1:0]  cpw_a_r;
  logic [ens_pkg::CPW_W-1:0]  cpw_b_r;
  logic [ens_pkg::INV_W-1:0]  invert_r;
  logic [ens_pkg::BCLK_W-1:0] bclk_r;
  logic [ens_pkg::SPT_W-1:0]  spt_r;

  // latched input word
  logic [1:0]                  cmd_r;
  logic                        ch_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [ens_pkg::TIME_W-1:0]  btime_r;

  // per-channel history
  logic                        first_r [CHANNELS];
  logic [WW-1:0]               wrap_r  [CHANNELS];
  logic [WW-1:0]               lwrap_r [CHANNELS];
  logic [CNT_W-1:0]            lcnt_r  [CHANNELS];
  logic [ens_pkg::TIME_W-1:0]  lbt_r   [CHANNELS];

  // history of the addressed channel
  logic                        sel_first;
  logic [WW-1:0]               sel_wrap;
  logic [WW-1:0]               sel_lwrap;
  logic [CNT_W-1:0]            sel_lcnt;
  logic [ens_pkg::TIME_W-1:0]  sel_lbt;

  // measurement datapath
  logic [WW-1:0]                 wd_r;
  logic [ens_pkg::CPW_W-1:0]     cpw_r;
  logic [WW-1:0]                 cdiff_r;
  logic [ens_pkg::DEN_W-1:0]     den_r;
  logic [WW-1:0]                 delta_r;
  logic [WW-1:0]                 speed_r;
  logic                          err_r;
  logic                          neg_r;
  logic [WW-1:0]                 delta_mag;
  logic [ens_pkg::DEN_W-1:0]     den_mag;
  logic                          inv_sel;

  // output register
  logic          out_tvalid_r;
  logic [WW-1:0] out_speed_r;
  logic [WW-1:0] out_delta_r;
  logic          out_err_r;
  logic          out_load;

  // serial units
  logic                        mul_start;
  logic                        div_start;
  logic [WW-1:0]               mul_a;
  logic [WW-1:0]               mul_b;
  logic [ens_pkg::NUM_W-1:0]   mul_prod;
  logic [ens_pkg::NUM_W-1:0]   div_quo;
  ens_pkg::ens_sts_t           mul_sts;
  ens_pkg::ens_sts_t           div_sts;

  logic in_acc;
  logic ch_ok;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ch_ok     = (int'(in_tuser[2]) < CHANNELS);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpw_a_r  <= ens_pkg::CPW_RST;
      cpw_b_r  <= ens_pkg::CPW_RST;
      invert_r <= ens_pkg::INV_RST;
      bclk_r   <= ens_pkg::BCLK_RST;
      spt_r    <= ens_pkg::SPT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        ens_pkg::CFG_CPW_A:       cpw_a_r  <= cfg_wdata[ens_pkg::CPW_W-1:0];
        ens_pkg::CFG_CPW_B:       cpw_b_r  <= cfg_wdata[ens_pkg::CPW_W-1:0];
        ens_pkg::CFG_INVERT:      invert_r <= cfg_wdata[ens_pkg::INV_W-1:0];
        ens_pkg::CFG_BASE_CLK:    bclk_r   <= cfg_wdata[ens_pkg::BCLK_W-1:0];
        ens_pkg::CFG_SAMPLE_TICK: spt_r    <= cfg_wdata[ens_pkg::SPT_W-1:0];
        default: ;
      endcase
    end
  end

  // pick the addressed channel's history
  always_comb begin
    sel_first = 1'b0;
    sel_wrap  = '0;
    sel_lwrap = '0;
    sel_lcnt  = '0;
    sel_lbt   = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c == int'(ch_r)) begin
        sel_first = first_r[c];
        sel_wrap  = wrap_r[c];
        sel_lwrap = lwrap_r[c];
        sel_lcnt  = lcnt_r[c];
        sel_lbt   = lbt_r[c];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && ch_ok) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_r != ens_pkg::CMD_MEASURE) state_nxt = S_IDLE;
        else if (sel_first)                state_nxt = S_FIN;
        else                               state_nxt = S_PROD;
      end
      S_PROD:  state_nxt = S_DELTA;
      S_DELTA: begin
        if (mul_sts.done) state_nxt = S_MULGO;
      end
      S_MULGO: state_nxt = S_MUL;
      S_MUL: begin
        if (mul_sts.done) state_nxt = (den_r == '0) ? S_FIN : S_DIV;
      end
      S_DIV: begin
        if (div_sts.done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // latch the accepted word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_tuser[1:0];
      ch_r    <= in_tuser[2];
      cnt_r   <= in_tdata[CNT_W-1:0];
      btime_r <= in_tdata[31:16];
    end
  end

  // channel history updates, all done in the execute cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        first_r[c] <= 1'b1;
        wrap_r[c]  <= '0;
        lwrap_r[c] <= '0;
        lcnt_r[c]  <= '0;
        lbt_r[c]   <= '0;
      end
    end else if (state_r == S_EXEC) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (c == int'(ch_r)) begin
          case (cmd_r)
            ens_pkg::CMD_WRAP_UP:   wrap_r[c] <= wrap_r[c] + 1'b1;
            ens_pkg::CMD_WRAP_DOWN: wrap_r[c] <= wrap_r[c] - 1'b1;
            ens_pkg::CMD_RESTART: begin
              wrap_r[c]  <= '0;
              first_r[c] <= 1'b1;
            end
            ens_pkg::CMD_MEASURE: begin
              lbt_r[c]  <= btime_r;
              lcnt_r[c] <= cnt_r;
              if (first_r[c]) begin
                // first measurement restarts the wrap bookkeeping
                first_r[c] <= 1'b0;
                wrap_r[c]  <= '0;
                lwrap_r[c] <= '0;
              end else begin
                lwrap_r[c] <= wrap_r[c];
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // measurement datapath
  assign delta_mag = delta_r[WW-1] ? (WW'(0) - delta_r) : delta_r;
  assign den_mag   = den_r[ens_pkg::DEN_W-1] ? (ens_pkg::DEN_W'(0) - den_r) : den_r;
  // first multiplier pass: wrap difference times counts per wrap
  // second pass: delta magnitude times base clock
  assign mul_a     = (state_r == S_PROD) ? wd_r : delta_mag;
  assign mul_b     = (state_r == S_PROD) ? {{(WW-ens_pkg::CPW_W){1'b0}}, cpw_r} : bclk_r;
  assign mul_start = (state_r == S_PROD) || (state_r == S_MULGO);
  assign div_start = (state_r == S_MUL) && mul_sts.done && (den_r != '0);

  always_ff @(posedge clk) begin
    case (state_r)
      S_EXEC: begin
        wd_r    <= sel_wrap - sel_lwrap;
        cpw_r   <= ch_r ? cpw_b_r : cpw_a_r;
        cdiff_r <= {{(WW-CNT_W){1'b0}}, cnt_r} - {{(WW-CNT_W){1'b0}}, sel_lcnt};
        // elapsed ticks plus sample period, signed
        den_r   <= {{(ens_pkg::DEN_W-ens_pkg::TIME_W){1'b0}}, btime_r}
                 - {{(ens_pkg::DEN_W-ens_pkg::TIME_W){1'b0}}, sel_lbt}
                 + {{(ens_pkg::DEN_W-ens_pkg::SPT_W){1'b0}}, spt_r};
        // first measurement reports the raw count
        delta_r <= {{(WW-CNT_W){1'b0}}, cnt_r};
        speed_r <= '0;
        err_r   <= 1'b0;
      end
      S_DELTA: begin
        // product wraps to 32 bits
        if (mul_sts.done) delta_r <= mul_prod[WW-1:0] + cdiff_r;
      end
      S_MULGO: neg_r   <= delta_r[WW-1] ^ den_r[ens_pkg::DEN_W-1];
      S_MUL: begin
        if (mul_sts.done && (den_r == '0)) begin
          err_r   <= 1'b1;
          speed_r <= '0;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          speed_r <= neg_r ? (WW'(0) - div_quo[WW-1:0]) : div_quo[WW-1:0];
        end
      end
      default: ;
    endcase
  end

  ens_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .sts   (mul_sts)
  );

  ens_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_prod),
    .den   (den_mag),
    .quo   (div_quo),
    .sts   (div_sts)
  );

  // output register, applies the channel's invert bit
  assign inv_sel  = invert_r[ch_r];
  assign out_load = (state_r == S_FIN) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_speed_r <= inv_sel ? (WW'(0) - speed_r) : speed_r;
      out_delta_r <= inv_sel ? (WW'(0) - delta_r) : delta_r;
      out_err_r   <= err_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_delta_r, out_speed_r};
  assign out_tuser  = out_err_r;

  // a divide error always carries a zero speed
  a_err_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[31:0] == '0)
    else $error("divide error with nonzero speed");

  // multiplier and divider never run at the same time
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_sts.busy && div_sts.busy))
    else $error("multiplier and divider both busy");

  // the divider never starts on a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> den_mag != '0)
    else $error("divider started with zero divisor");

  // an accepted word for a present channel holds off the next one
  a_accept_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && ch_ok |=> !in_tready)
    else $error("second word taken while first still in work");

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the encoder speed measurement block
`timescale 1ns / 1ps

module tb_top;

  localparam int PHASE_WORDS = 255;    // random words per configuration phase
  localparam int SETTLE_CYCLES = 200;  // extra wait once every result is back
  localparam int HOLD_AT = 300;        // words taken before the long receiver hold-off
  localparam int HOLD_LEN = 800;       // cycles of that hold-off
  localparam logic [2:0] KEEP = 3'd0;  // directed row keeps the current settings

  // one result word as the block returns it
  typedef struct packed {
    logic [31:0] speed;
    logic [31:0] delta;
    logic        err;
  } meas_t;

  // raw register values, masked to width by the block
  typedef struct packed {
    logic [31:0] cpw_a;
    logic [31:0] cpw_b;
    logic [31:0] inv;
    logic [31:0] bclk;
    logic [31:0] spt;
  } settings_t;

  // one directed word, with a typed result where it is obvious
  typedef struct packed {
    logic [2:0]  set_sel;
    logic [1:0]  cmd;
    logic        ch;
    logic [15:0] cnt;
    logic [15:0] bt;
    logic        typed;
    logic [31:0] speed;
    logic [31:0] delta;
    logic        err;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] encoder_count, [31:16] base_time
  logic [2:0]  in_tuser;   // [1:0] command, [2] channel
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [31:0] speed, [63:32] count_delta
  logic        out_tuser;  // [0] divide_error
  logic        cfg_we;
  logic [ens_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [ens_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // shadow of the configuration registers
  logic [16:0] cpw_reg [2];
  logic [1:0]  invert_reg;
  logic [31:0] bclk_reg;
  logic [30:0] spt_reg;

  // shadow of the per-channel history
  bit          first_due [2];
  logic [31:0] wraps [2];
  logic [31:0] last_wraps [2];
  logic [15:0] last_cnt [2];
  logic [15:0] last_bt [2];

  meas_t     pending_results [$];
  int        mismatches;
  int        words_taken;
  bit        steady;  // both sides stop idling while set
  row_t      plan [23];
  settings_t dir_sets [4];

  encoder_speed_measurement u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // expected behavior of one accepted word; returns 1 when a result follows
  function automatic bit predict_measurement(input logic [1:0] cmd, input logic ch,
                                             input logic [15:0] cnt,
                                             input logic [15:0] bt, output meas_t m);
    logic [31:0] wd;
    logic [31:0] prod;
    logic [31:0] delta;
    logic [31:0] speed;
    logic        err;
    longint      num;
    longint      den;
    longint      quo;
    m = '0;
    speed = '0;
    delta = '0;
    err = 1'b0;
    case (cmd)
      ens_pkg::CMD_WRAP_UP: begin
        wraps[ch] = wraps[ch] + 32'd1;
        return 1'b0;
      end
      ens_pkg::CMD_WRAP_DOWN: begin
        wraps[ch] = wraps[ch] - 32'd1;
        return 1'b0;
      end
      ens_pkg::CMD_RESTART: begin
        wraps[ch] = '0;
        first_due[ch] = 1'b1;
        return 1'b0;
      end
      default: ;
    endcase
    if (first_due[ch]) begin
      // first measurement only reports the raw counter and starts the history
      first_due[ch] = 1'b0;
      wraps[ch] = '0;
      last_wraps[ch] = '0;
      delta = {16'd0, cnt};
    end else begin
      wd = wraps[ch] - last_wraps[ch];
      prod = wd * {15'd0, cpw_reg[ch]};
      delta = prod + {16'd0, cnt} - {16'd0, last_cnt[ch]};
      num = longint'(signed'(delta)) * longint'({32'd0, bclk_reg});
      den = longint'({48'd0, bt}) - longint'({48'd0, last_bt[ch]})
            + longint'({33'd0, spt_reg});
      if (den == 0) begin
        err = 1'b1;
      end else begin
        // signed division truncates toward zero
        quo = num / den;
        speed = quo[31:0];
      end
      last_wraps[ch] = wraps[ch];
    end
    last_cnt[ch] = cnt;
    last_bt[ch] = bt;
    if (invert_reg[ch]) begin
      speed = -speed;
      delta = -delta;
    end
    m = '{speed, delta, err};
    return 1'b1;
  endfunction

  // offer one command word and book its result once it is taken
  task automatic send_word(input logic [1:0] cmd, input logic ch, input logic [15:0] cnt,
                           input logic [15:0] bt, input bit typed, input meas_t typed_val);
    meas_t m;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {bt, cnt};
    in_tuser <= {ch, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_measurement(cmd, ch, cnt, bt, m))
      pending_results.push_back(typed ? typed_val : m);
    words_taken++;
  endtask

  // stop offering, let every result come back, then give the block time to go idle
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_word(input logic [ens_pkg::CFG_ADDR_W-1:0] addr,
                          input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
  endtask

  // write every register, plus one index past the list that must be ignored
  task automatic load_settings(input settings_t s);
    cfg_word(ens_pkg::CFG_CPW_A, s.cpw_a);
    cfg_word(ens_pkg::CFG_CPW_B, s.cpw_b);
    cfg_word(ens_pkg::CFG_INVERT, s.inv);
    cfg_word(ens_pkg::CFG_BASE_CLK, s.bclk);
    cfg_word(ens_pkg::CFG_SAMPLE_TICK, s.spt);
    cfg_word(ens_pkg::CFG_SAMPLE_TICK + 3'($urandom_range(3, 1)), $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    cpw_reg[0] = s.cpw_a[16:0];
    cpw_reg[1] = s.cpw_b[16:0];
    invert_reg = s.inv[1:0];
    bclk_reg = s.bclk;
    spt_reg = s.spt[30:0];
  endtask

  // measurements mixed with wrap words and restarts, with times near the last one so
  // that small periods give zero and negative divisors
  task automatic random_words(input int n);
    logic [1:0]  cmd;
    logic        ch;
    logic [15:0] cnt;
    logic [15:0] bt;
    int          r;
    int          k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 30) cmd = ens_pkg::CMD_WRAP_UP;
      else if (r < 48) cmd = ens_pkg::CMD_WRAP_DOWN;
      else if (r < 92) cmd = ens_pkg::CMD_MEASURE;
      else cmd = ens_pkg::CMD_RESTART;
      ch = 1'($urandom_range(1));
      if ($urandom_range(3) == 0) cnt = 16'($urandom);
      else cnt = last_cnt[ch] + 16'($urandom_range(4095)) - 16'd2048;
      k = $urandom_range(9);
      if (k < 6) bt = last_bt[ch] + 16'($urandom_range(3000));
      else if (k == 6 && spt_reg < 31'd65536) bt = last_bt[ch] - spt_reg[15:0];
      else if (k == 7) bt = last_bt[ch] - 16'($urandom_range(200));
      else bt = 16'($urandom);
      send_word(cmd, ch, cnt, bt, 1'b0, '0);
    end
  endtask

  // receiver: random stalls, one long hold-off that backs the block up
  initial begin : result_sink
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && !held && words_taken >= HOLD_AT) begin
        out_tready <= 1'b0;
        held = 1'b1;
        hold_left = HOLD_LEN;
      end else if (hold_left != 0) begin
        hold_left--;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 19);
      end
    end
  end

  // compare each returned word with the oldest booked result
  always @(posedge clk) begin : result_check
    meas_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        log_mismatch("unexpected word, speed", out_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.speed)
          log_mismatch("speed", out_tdata[31:0], want.speed);
        if (out_tdata[63:32] !== want.delta)
          log_mismatch("count_delta", out_tdata[63:32], want.delta);
        if (out_tuser !== want.err)
          log_mismatch("divide_error", {31'd0, out_tuser}, {31'd0, want.err});
      end
    end
  end

  initial begin : stimulus
    settings_t s;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    mismatches = 0;
    words_taken = 0;
    steady = 1'b0;

    // shadow state at reset
    cpw_reg[0] = ens_pkg::CPW_RST;
    cpw_reg[1] = ens_pkg::CPW_RST;
    invert_reg = ens_pkg::INV_RST;
    bclk_reg = ens_pkg::BCLK_RST;
    spt_reg = ens_pkg::SPT_RST;
    for (int c = 0; c < 2; c++) begin
      first_due[c] = 1'b1;
      wraps[c] = '0;
      last_wraps[c] = '0;
      last_cnt[c] = '0;
      last_bt[c] = '0;
    end

    // settings of the directed part: unit period, huge period, zero period
    dir_sets[0] = '0;
    dir_sets[1] = '{32'd1, 32'd65536, 32'd2, 32'hFFFF_FFFF, 32'd1};
    dir_sets[2] = '{32'd0, 32'h1_FFFF, 32'd3, 32'd1, 32'h7FFF_FFFF};
    dir_sets[3] = '{32'd65536, 32'd1, 32'd1, 32'd0, 32'd0};

    plan = '{
      // first measurements after reset report the raw counter
      '{KEEP, ens_pkg::CMD_MEASURE,   1'b0, 16'd0,    16'd0,    1'b1, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_MEASURE,   1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 32'd0, 32'd65535,
        1'b0},
      '{KEEP, ens_pkg::CMD_WRAP_UP,   1'b0, 16'd0,    16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_WRAP_UP,   1'b0, 16'd0,    16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_WRAP_DOWN, 1'b0, 16'd0,    16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_MEASURE,   1'b0, 16'd100,  16'd1000, 1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_MEASURE,   1'b1, 16'd0,    16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      // restart goes back to the first-measurement path
      '{KEEP, ens_pkg::CMD_RESTART,   1'b0, 16'd0,    16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_MEASURE,   1'b0, 16'd1234, 16'd5,    1'b1, 32'd0, 32'd1234, 1'b0},
      // unit period: divisor of one, then zero, then negative
      '{3'd1, ens_pkg::CMD_MEASURE,   1'b0, 16'd2000, 16'd5,    1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_MEASURE,   1'b0, 16'd2000, 16'd4,    1'b1, 32'd0, 32'd0,   1'b1},
      '{KEEP, ens_pkg::CMD_MEASURE,   1'b0, 16'd0,    16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      // inverted channel, first measurement negated
      '{KEEP, ens_pkg::CMD_RESTART,   1'b1, 16'd0,    16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_MEASURE,   1'b1, 16'd7,    16'd9,    1'b1, 32'd0, -32'sd7, 1'b0},
      '{KEEP, ens_pkg::CMD_WRAP_UP,   1'b1, 16'd0,    16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_MEASURE,   1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0, 32'd0,   1'b0},
      // zero and oversized counts per wrap, largest period
      '{3'd2, ens_pkg::CMD_WRAP_UP,   1'b0, 16'd0,    16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_MEASURE,   1'b0, 16'hFFFF, 16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_WRAP_DOWN, 1'b1, 16'd0,    16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_WRAP_DOWN, 1'b1, 16'd0,    16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_MEASURE,   1'b1, 16'd0,    16'hFFFF, 1'b0, 32'd0, 32'd0,   1'b0},
      // zero period and zero base clock
      '{3'd3, ens_pkg::CMD_MEASURE,   1'b0, 16'd5,    16'd0,    1'b0, 32'd0, 32'd0,   1'b0},
      '{KEEP, ens_pkg::CMD_MEASURE,   1'b1, 16'd3,    16'd2,    1'b0, 32'd0, 32'd0,   1'b0}
    };

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].set_sel != KEEP) begin
        settle();
        load_settings(dir_sets[plan[i].set_sel]);
      end
      send_word(plan[i].cmd, plan[i].ch, plan[i].cnt, plan[i].bt, plan[i].typed,
                '{plan[i].speed, plan[i].delta, plan[i].err});
    end

    // random phases, each under its own settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: s = '{32'(ens_pkg::CPW_RST), 32'(ens_pkg::CPW_RST), 32'(ens_pkg::INV_RST),
                 32'(ens_pkg::BCLK_RST), 32'(ens_pkg::SPT_RST)};
        2: s = '{32'($urandom_range(16, 1)), 32'($urandom_range(16, 1)), $urandom,
                 $urandom, 32'($urandom_range(300))};
        3: s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        4: s = '{32'd65536, 32'd65536, $urandom, $urandom, 32'($urandom_range(70000, 1))};
        default: s = '{$urandom, $urandom, $urandom, $urandom, $urandom};
      endcase
      settle();
      load_settings(s);
      // the small-period phase also runs with no idling on either side
      steady = (p == 2);
      random_words(PHASE_WORDS);
      steady = 1'b0;
    end

    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- encoder_speed_measurement.f -----
design/ens_pkg.sv
design/ens_mul.sv
design/ens_div.sv
design/encoder_speed_measurement.sv
tb/tb_top.sv
